>>> sv/crc16fr_pkg.sv
`default_nettype none

package crc16fr_pkg;

	localparam int MAX_DATA_BYTES = 8;

	localparam int BYTE_W     = 8;
	localparam int STATUS_W   = 3;
	localparam int BYTE_POS_W = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int FRAME_BASE_LEN = 8;
	localparam int POS_W = $clog2(FRAME_BASE_LEN + MAX_DATA_BYTES);
	localparam int LEN_W = $clog2(FRAME_BASE_LEN + MAX_DATA_BYTES + 1);

	localparam logic [BYTE_W-1:0] HDR0_BYTE  = 8'h77;
	localparam logic [BYTE_W-1:0] HDR1_BYTE  = 8'h99;
	localparam logic [BYTE_W-1:0] BCAST_ADDR = 8'hFF;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [BYTE_W-1:0] DEV_ADDR_RST   = 8'd1;
	localparam logic [BYTE_W-1:0] READ_CODE_RST  = 8'd3;
	localparam logic [BYTE_W-1:0] WRITE_CODE_RST = 8'd16;

	typedef enum logic [STATUS_W-1:0] {
		ST_COLLECT    = 3'd0,
		ST_GOOD       = 3'd1,
		ST_BAD_HEADER = 3'd2,
		ST_BAD_ADDR   = 3'd3,
		ST_BAD_FUNC   = 3'd4,
		ST_BAD_CRC    = 3'd5,
		ST_COUNT_HIGH = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEV_ADDR   = 2'd0,
		CFG_READ_CODE  = 2'd1,
		CFG_WRITE_CODE = 2'd2
	} cfg_idx_t;

	// CRC-16/MODBUS, one byte, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> sv/crc16fr_in_if.sv
`default_nettype none

interface crc16fr_in_if;
	import crc16fr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);

endinterface

`default_nettype wire

>>> sv/crc16fr_out_if.sv
`default_nettype none

interface crc16fr_out_if;
	import crc16fr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [BYTE_POS_W-1:0] byte_pos;
	logic [BYTE_W-1:0]     byte_value;
	logic                  is_write;
	logic                  is_broadcast;
	logic [BYTE_W-1:0]     start_register;
	logic [BYTE_W-1:0]     register_count;

	modport source (
		output valid, output status, output byte_pos, output byte_value,
		output is_write, output is_broadcast, output start_register,
		output register_count, input ready
	);
	modport sink (
		input valid, input status, input byte_pos, input byte_value,
		input is_write, input is_broadcast, input start_register,
		input register_count, output ready
	);

endinterface

`default_nettype wire

>>> sv/crc16_frame_receiver_core.sv
`default_nettype none

// Request frame checker for a serial byte stream: 0x77 0x99 addr func start count
// [data] crc_lo crc_hi, with CRC-16/MODBUS over addr..data. Every received byte
// beat yields one result beat carrying a status (collecting, good, or the reason
// the frame was dropped) plus the frame fields captured so far. The frame state and
// the result register update at the edge the byte is accepted, so one byte per
// clock is sustained while the result side keeps up; the result register lets the
// next byte in during the cycle its result is taken.
// Register writes (own address, read code, write code) are meant for idle times.
module crc16_frame_receiver_core (
	input  wire                               clk,
	input  wire                               arst_n,
	crc16fr_in_if.sink                        rx,
	crc16fr_out_if.source                     result,
	input  wire                               cfg_we,
	input  wire [crc16fr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [crc16fr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import crc16fr_pkg::*;

	localparam int CMP_W = LEN_W + 1;

	logic [BYTE_W-1:0] dev_addr_q;
	logic [BYTE_W-1:0] read_code_q;
	logic [BYTE_W-1:0] write_code_q;

	logic [POS_W-1:0]  pos_q;
	logic [15:0]       crc_q;
	logic              wr_flag_q;
	logic              bc_flag_q;
	logic [BYTE_W-1:0] start_q;
	logic [BYTE_W-1:0] count_q;
	logic [LEN_W-1:0]  exp_len_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [BYTE_POS_W-1:0] out_pos_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_wr_q;
	logic              out_bc_q;
	logic [BYTE_W-1:0] out_start_q;
	logic [BYTE_W-1:0] out_count_q;

	logic              accept;
	logic [BYTE_W-1:0] b;

	// frame state seen by this byte (cleared at frame start)
	logic              first;
	logic [15:0]       cur_crc;
	logic              cur_wr;
	logic              cur_bc;
	logic [BYTE_W-1:0] cur_start;
	logic [BYTE_W-1:0] cur_count;
	logic [LEN_W-1:0]  cur_exp;

	status_t           st;
	logic [15:0]       nxt_crc;
	logic              nxt_wr;
	logic              nxt_bc;
	logic [BYTE_W-1:0] nxt_start;
	logic [BYTE_W-1:0] nxt_count;
	logic [LEN_W-1:0]  nxt_exp;
	logic [15:0]       crc_upd;
	logic [CMP_W-1:0]  pos_plus2;
	logic [CMP_W-1:0]  exp_ext;

	assign rx.ready = !out_valid_q || result.ready;
	assign accept   = rx.valid && rx.ready;
	assign b        = rx.rx_byte;

	assign first     = (pos_q == '0);
	assign cur_crc   = first ? CRC_INIT : crc_q;
	assign cur_wr    = first ? 1'b0 : wr_flag_q;
	assign cur_bc    = first ? 1'b0 : bc_flag_q;
	assign cur_start = first ? '0 : start_q;
	assign cur_count = first ? '0 : count_q;
	assign cur_exp   = first ? LEN_W'(FRAME_BASE_LEN) : exp_len_q;

	assign crc_upd   = crc_byte(cur_crc, b);
	assign pos_plus2 = CMP_W'(pos_q) + CMP_W'(2);
	assign exp_ext   = CMP_W'(cur_exp);

	always_comb begin
		st        = ST_COLLECT;
		nxt_crc   = cur_crc;
		nxt_wr    = cur_wr;
		nxt_bc    = cur_bc;
		nxt_start = cur_start;
		nxt_count = cur_count;
		nxt_exp   = cur_exp;
		if (pos_q == POS_W'(0)) begin
			if (b != HDR0_BYTE) st = ST_BAD_HEADER;
		end else if (pos_q == POS_W'(1)) begin
			if (b != HDR1_BYTE) st = ST_BAD_HEADER;
		end else if (pos_q == POS_W'(2)) begin
			if (b != dev_addr_q && b != BCAST_ADDR) begin
				st = ST_BAD_ADDR;
			end else begin
				nxt_bc  = (b == BCAST_ADDR);
				nxt_crc = crc_upd;
			end
		end else if (pos_q == POS_W'(3)) begin
			if (b == read_code_q) begin
				nxt_wr  = 1'b0;
				nxt_crc = crc_upd;
			end else if (b == write_code_q) begin
				nxt_wr  = 1'b1;
				nxt_crc = crc_upd;
			end else begin
				st = ST_BAD_FUNC;
			end
		end else if (pos_q == POS_W'(4)) begin
			nxt_start = b;
			nxt_crc   = crc_upd;
		end else if (pos_q == POS_W'(5)) begin
			nxt_count = b;
			if (cur_wr && b > BYTE_W'(MAX_DATA_BYTES)) begin
				st = ST_COUNT_HIGH;
			end else begin
				nxt_exp = cur_wr ? LEN_W'(FRAME_BASE_LEN) + LEN_W'(b)
				                 : LEN_W'(FRAME_BASE_LEN);
				nxt_crc = crc_upd;
			end
		end else if (pos_plus2 < exp_ext) begin
			nxt_crc = crc_upd;
		end else if (pos_plus2 == exp_ext) begin
			if (b != cur_crc[7:0]) st = ST_BAD_CRC;
		end else begin
			st = (b == cur_crc[15:8]) ? ST_GOOD : ST_BAD_CRC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q   <= DEV_ADDR_RST;
			read_code_q  <= READ_CODE_RST;
			write_code_q <= WRITE_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DEV_ADDR:   dev_addr_q   <= cfg_wdata;
				CFG_READ_CODE:  read_code_q  <= cfg_wdata;
				CFG_WRITE_CODE: write_code_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= CRC_INIT;
			wr_flag_q <= 1'b0;
			bc_flag_q <= 1'b0;
			start_q   <= '0;
			count_q   <= '0;
			exp_len_q <= LEN_W'(FRAME_BASE_LEN);
		end else if (accept) begin
			pos_q     <= (st == ST_COLLECT) ? pos_q + POS_W'(1) : '0;
			crc_q     <= nxt_crc;
			wr_flag_q <= nxt_wr;
			bc_flag_q <= nxt_bc;
			start_q   <= nxt_start;
			count_q   <= nxt_count;
			exp_len_q <= nxt_exp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= st;
			out_pos_q    <= pos_q[BYTE_POS_W-1:0];
			out_byte_q   <= b;
			out_wr_q     <= nxt_wr;
			out_bc_q     <= nxt_bc;
			out_start_q  <= nxt_start;
			out_count_q  <= nxt_count;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.status         = out_status_q;
	assign result.byte_pos       = out_pos_q;
	assign result.byte_value     = out_byte_q;
	assign result.is_write       = out_wr_q;
	assign result.is_broadcast   = out_bc_q;
	assign result.start_register = out_start_q;
	assign result.register_count = out_count_q;

endmodule

`default_nettype wire

>>> dv/crc16_frame_receiver_core_tb.sv
module crc16_frame_receiver_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crc16fr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	typedef struct packed {
		status_t                 status;
		logic [BYTE_POS_W-1:0]   pos;
		logic [BYTE_W-1:0]       value;
		logic                    wr;
		logic                    bc;
		logic [BYTE_W-1:0]       start;
		logic [BYTE_W-1:0]       count;
	} byte_result_t;

	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_CRC_LO,
		ROW_CRC_HI
	} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [BYTE_W-1:0]     value;
		logic                  typed;
		status_t               st;
		logic [BYTE_POS_W-1:0] pos;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	crc16fr_in_if  rx_if();
	crc16fr_out_if res_if();

	crc16_frame_receiver_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.result(res_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// receiver model state
	logic [BYTE_W-1:0] own_addr, rd_code, wr_code;
	int                fr_pos;
	int                fr_len;
	logic [15:0]       crc_run;
	logic              wr_flag, bc_flag;
	logic [BYTE_W-1:0] start_hold, count_hold;

	byte_result_t results_due[$];
	int fail_count = 0;
	int bytes_sent = 0;
	int status_seen[8];
	bit calm = 1'b0;

	dir_row_t dir_rows [24] = '{
		'{ROW_BYTE,   8'h00, 1'b1, ST_BAD_HEADER, 4'd0},
		'{ROW_BYTE,   8'h77, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'hFF, 1'b1, ST_BAD_HEADER, 4'd1},
		'{ROW_BYTE,   8'h77, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'h99, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'h02, 1'b1, ST_BAD_ADDR,   4'd2},
		'{ROW_BYTE,   8'h77, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'h99, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'hFF, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'h00, 1'b1, ST_BAD_FUNC,   4'd3},
		'{ROW_BYTE,   8'h77, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'h99, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'h01, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'h10, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'h00, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'h09, 1'b1, ST_COUNT_HIGH, 4'd5},
		'{ROW_BYTE,   8'h77, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'h99, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'h01, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'h03, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'hFF, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_BYTE,   8'h07, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_CRC_LO, 8'h00, 1'b0, ST_COLLECT,    4'd0},
		'{ROW_CRC_HI, 8'h00, 1'b1, ST_GOOD,       4'd7}
	};

	// reflected CRC-16, one data bit per step
	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] r;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			r = (r >> 1) ^ ((r[0] ^ d[i]) ? CRC_POLY : 16'h0000);
		end
		return r;
	endfunction

	function byte_result_t track_frame_byte(input logic [BYTE_W-1:0] b);
		byte_result_t res;
		status_t      st;
		int           at;
		if (fr_pos == 0) begin
			crc_run = CRC_INIT;
			wr_flag = 1'b0;
			bc_flag = 1'b0;
			start_hold = '0;
			count_hold = '0;
			fr_len = FRAME_BASE_LEN;
		end
		at = fr_pos;
		st = ST_COLLECT;
		if (at == 0) begin
			if (b != HDR0_BYTE) st = ST_BAD_HEADER;
		end else if (at == 1) begin
			if (b != HDR1_BYTE) st = ST_BAD_HEADER;
		end else if (at == 2) begin
			if (b != own_addr && b != BCAST_ADDR) begin
				st = ST_BAD_ADDR;
			end else begin
				bc_flag = (b == BCAST_ADDR);
				crc_run = crc16_step(crc_run, b);
			end
		end else if (at == 3) begin
			if (b == rd_code) begin
				wr_flag = 1'b0;
				crc_run = crc16_step(crc_run, b);
			end else if (b == wr_code) begin
				wr_flag = 1'b1;
				crc_run = crc16_step(crc_run, b);
			end else begin
				st = ST_BAD_FUNC;
			end
		end else if (at == 4) begin
			start_hold = b;
			crc_run = crc16_step(crc_run, b);
		end else if (at == 5) begin
			count_hold = b;
			if (wr_flag && b > MAX_DATA_BYTES) begin
				st = ST_COUNT_HIGH;
			end else begin
				fr_len = wr_flag ? FRAME_BASE_LEN + int'(b) : FRAME_BASE_LEN;
				crc_run = crc16_step(crc_run, b);
			end
		end else if (at + 2 < fr_len) begin
			crc_run = crc16_step(crc_run, b);
		end else if (at + 2 == fr_len) begin
			if (b != crc_run[7:0]) st = ST_BAD_CRC;
		end else begin
			st = (b == crc_run[15:8]) ? ST_GOOD : ST_BAD_CRC;
		end
		res.status = st;
		res.pos = at[BYTE_POS_W-1:0];
		res.value = b;
		res.wr = wr_flag;
		res.bc = bc_flag;
		res.start = start_hold;
		res.count = count_hold;
		fr_pos = (st != ST_COLLECT) ? 0 : at + 1;
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		byte_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (results_due.size() == 0) begin
				$error("result beat with nothing pending: status %0d pos %0d",
					res_if.status, res_if.byte_pos);
				fail_count++;
			end else begin
				want = results_due.pop_front();
				check_field("status", want.status, res_if.status);
				check_field("byte_pos", want.pos, res_if.byte_pos);
				check_field("byte_value", want.value, res_if.byte_value);
				check_field("is_write", want.wr, res_if.is_write);
				check_field("is_broadcast", want.bc, res_if.is_broadcast);
				check_field("start_register", want.start, res_if.start_register);
				check_field("register_count", want.count, res_if.register_count);
				status_seen[want.status]++;
			end
		end
	end

	// result-side backpressure
	initial begin
		int hold;
		hold = 0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				res_if.ready <= 1'b0;
				hold--;
			end else begin
				res_if.ready <= 1'b1;
				hold = pick_gap();
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b, output byte_result_t got);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		got = track_frame_byte(b);
		results_due.push_back(got);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		if (results_due.size() != 0) begin
			rx_if.valid <= 1'b0;
			while (results_due.size() != 0) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		case (idx)
			CFG_DEV_ADDR:   own_addr = val;
			CFG_READ_CODE:  rd_code = val;
			CFG_WRITE_CODE: wr_code = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] rc,
			input logic [BYTE_W-1:0] wc, input bit poke_unused);
		wait_drained();
		repeat (3) @(negedge clk);
		write_reg(CFG_DEV_ADDR, a);
		write_reg(CFG_READ_CODE, rc);
		write_reg(CFG_WRITE_CODE, wc);
		if (poke_unused) write_reg(CFG_UNUSED_IDX, 8'($urandom_range(0, 255)));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_noise();
		int n;
		byte_result_t got;
		n = $urandom_range(1, 4);
		repeat (n) begin
			send_byte(($urandom_range(0, 1) != 0) ? HDR0_BYTE : 8'($urandom_range(0, 255)), got);
		end
	endtask

	task automatic send_frame();
		logic [BYTE_W-1:0] fr[$];
		logic [BYTE_W-1:0] a, f, cnt;
		logic [15:0] c;
		logic wr;
		int r;
		byte_result_t got;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			a = own_addr;
		end else if (r < 88) begin
			a = BCAST_ADDR;
		end else begin
			do a = 8'($urandom_range(0, 255)); while (a == own_addr || a == BCAST_ADDR);
		end
		wr = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < 92) begin
			f = wr ? wr_code : rd_code;
		end else begin
			do f = 8'($urandom_range(0, 255)); while (f == rd_code || f == wr_code);
		end
		r = $urandom_range(0, 99);
		if (!wr) cnt = 8'($urandom_range(0, 255));
		else if (r < 8) cnt = 8'($urandom_range(MAX_DATA_BYTES + 1, 255));
		else if (r < 80) cnt = 8'($urandom_range(0, 3));
		else cnt = 8'($urandom_range(0, MAX_DATA_BYTES));
		fr = {HDR0_BYTE, HDR1_BYTE, a, f, 8'($urandom_range(0, 255)), cnt};
		if (wr && cnt <= MAX_DATA_BYTES) begin
			repeat (cnt) fr.push_back(8'($urandom_range(0, 255)));
		end
		c = CRC_INIT;
		for (int i = 2; i < fr.size(); i++) c = crc16_step(c, fr[i]);
		fr.push_back(c[7:0]);
		fr.push_back(c[15:8]);
		// occasional damage: header, low crc, high crc
		r = $urandom_range(0, 99);
		if (r < 4) fr[0] = fr[0] ^ 8'($urandom_range(1, 255));
		else if (r < 8) fr[1] = fr[1] ^ 8'($urandom_range(1, 255));
		else if (r < 13) fr[fr.size() - 2] = fr[fr.size() - 2] ^ 8'($urandom_range(1, 255));
		else if (r < 18) fr[fr.size() - 1] = fr[fr.size() - 1] ^ 8'($urandom_range(1, 255));
		foreach (fr[i]) begin
			send_byte(fr[i], got);
			if (got.status != ST_COLLECT) break;
		end
	endtask

	task automatic run_random(input int how_many);
		int stop_at;
		int r;
		stop_at = bytes_sent + how_many;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 4) calm = ~calm;
			if (r >= 96) wait_drained();
			if (r >= 86 && r < 96) send_noise();
			else send_frame();
		end
	endtask

	initial begin
		#1_000_000;
		$display("crc16_frame_receiver_core_tb NOT OK");
		$finish;
	end

	initial begin
		logic [BYTE_W-1:0] b, code;
		byte_result_t got;
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		own_addr = DEV_ADDR_RST;
		rd_code = READ_CODE_RST;
		wr_code = WRITE_CODE_RST;
		fr_pos = 0;
		fr_len = FRAME_BASE_LEN;
		crc_run = CRC_INIT;
		wr_flag = 1'b0;
		bc_flag = 1'b0;
		start_hold = '0;
		count_hold = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_CRC_LO: b = crc_run[7:0];
				ROW_CRC_HI: b = crc_run[15:8];
				default:    b = dir_rows[i].value;
			endcase
			send_byte(b, got);
			if (dir_rows[i].typed && (got.status !== dir_rows[i].st ||
					got.pos !== dir_rows[i].pos)) begin
				$error("directed beat %0d: status %0d pos %0d, table has status %0d pos %0d",
					i, got.status, got.pos, dir_rows[i].st, dir_rows[i].pos);
				fail_count++;
			end
		end

		run_random(100);
		set_config(8'h00, 8'h00, 8'hFF, 1'b0);
		run_random(100);
		// own address is the broadcast address
		set_config(8'hFF, 8'hFF, 8'h00, 1'b0);
		run_random(100);
		// read and write share one code: frames count as reads
		code = 8'($urandom_range(0, 255));
		set_config(8'($urandom_range(0, 254)), code, code, 1'b0);
		run_random(100);
		set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 1'b1);
		run_random(100);
		set_config(DEV_ADDR_RST, READ_CODE_RST, WRITE_CODE_RST, 1'b1);
		run_random(100);

		wait_drained();
		repeat (4) @(posedge clk);
		$display("%0d byte beats over 6 register settings: %0d good frames, %0d bad header,",
			bytes_sent, status_seen[ST_GOOD], status_seen[ST_BAD_HEADER]);
		$display("%0d bad address, %0d bad function, %0d bad crc, %0d count over limit",
			status_seen[ST_BAD_ADDR], status_seen[ST_BAD_FUNC], status_seen[ST_BAD_CRC],
			status_seen[ST_COUNT_HIGH]);
		if (fail_count == 0) begin
			$display("crc16_frame_receiver_core_tb OK");
		end else begin
			$display("crc16_frame_receiver_core_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> crc16_frame_receiver_core.f
sv/crc16fr_pkg.sv
sv/crc16fr_in_if.sv
sv/crc16fr_out_if.sv
sv/crc16_frame_receiver_core.sv
dv/crc16_frame_receiver_core_tb.sv
